>>> src/wft_pkg.sv
// Shared types, codes and the format table of the Wiegand frame transmitter.
// Used by every module of the block; depends on nothing else.
package wft_pkg;

  localparam int FRAME_BITS_DEF  = 64;
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int LEN_W           = 7;
  localparam int FLD_W           = 6;
  localparam int BUILD_W         = 64;

  localparam logic [CFG_W-1:0] PULSE_RST = 16'd50;
  localparam logic [CFG_W-1:0] GAP_RST   = 16'd2000;
  localparam logic [CFG_W-1:0] LEAD_RST  = 16'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE = 2'd0,
    REG_GAP   = 2'd1,
    REG_LEAD  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEAD  = 2'd1,
    PH_PULSE = 2'd2,
    PH_GAP   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_ACCEPTED   = 3'd1,
    ST_RANGE      = 3'd2,
    ST_BAD_FORMAT = 3'd3,
    ST_BUSY       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_PAR  = 2'd0,
    KIND_BARE = 2'd1,
    KIND_W35  = 2'd2
  } kind_t;

  typedef struct packed {
    logic             known;
    logic [LEN_W-1:0] len;
    logic [FLD_W-1:0] fbits;
    logic [FLD_W-1:0] cbits;
    logic [FLD_W-1:0] elen;
    kind_t            kind;
  } fmt_desc_t;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  format;
    logic [27:0] facility;
    logic [33:0] card;
  } in_item_t;

  typedef struct packed {
    logic    d0_line;
    logic    d1_line;
    logic    busy_res;
    logic [2:0] status;
    logic    frame_done;
  } out_item_t;

  // Result of the frame builder handed to the sequencer
  typedef struct packed {
    logic             fmt_known;
    logic             range_ok;
    logic [LEN_W-1:0] len;
  } build_info_t;

  function automatic fmt_desc_t fmt_lookup(input logic [3:0] f);
    fmt_desc_t d;
    d = '{known: 1'b1, len: 7'd0, fbits: 6'd0, cbits: 6'd0, elen: 6'd0, kind: KIND_PAR};
    case (f)
      4'd0:  begin d.len = 7'd26; d.fbits = 6'd8;  d.cbits = 6'd16; d.elen = 6'd12; end
      4'd1:  begin d.len = 7'd30; d.fbits = 6'd10; d.cbits = 6'd20; d.elen = 6'd15; end
      4'd2:  begin d.len = 7'd32; d.cbits = 6'd32; d.kind = KIND_BARE; end
      4'd3:  begin d.len = 7'd34; d.fbits = 6'd16; d.cbits = 6'd16; d.elen = 6'd16; end
      4'd4:  begin
        d.len = 7'd35; d.fbits = 6'd12; d.cbits = 6'd20; d.elen = 6'd34; d.kind = KIND_W35;
      end
      4'd5:  begin d.len = 7'd37; d.fbits = 6'd16; d.cbits = 6'd19; d.elen = 6'd18; end
      4'd6:  begin d.len = 7'd38; d.fbits = 6'd16; d.cbits = 6'd20; d.elen = 6'd18; end
      4'd7:  begin d.len = 7'd40; d.fbits = 6'd16; d.cbits = 6'd22; d.elen = 6'd19; end
      4'd8:  begin d.len = 7'd46; d.fbits = 6'd20; d.cbits = 6'd24; d.elen = 6'd22; end
      4'd9:  begin d.len = 7'd48; d.fbits = 6'd22; d.cbits = 6'd24; d.elen = 6'd23; end
      4'd10: begin d.len = 7'd56; d.fbits = 6'd24; d.cbits = 6'd30; d.elen = 6'd27; end
      4'd11: begin d.len = 7'd64; d.fbits = 6'd28; d.cbits = 6'd34; d.elen = 6'd31; end
      default: d.known = 1'b0;
    endcase
    return d;
  endfunction

endpackage

>>> src/wft_frame_build.sv
// Frame builder: range checks and bit layout of one start request.
// Depends on wft_pkg for the format table and the shared types.
module wft_frame_build import wft_pkg::*; (
  input  logic [3:0]         format,
  input  logic [27:0]        facility,
  input  logic [33:0]        card,
  output build_info_t        info,
  output logic [BUILD_W-1:0] frame
);

  fmt_desc_t          d;
  logic [LEN_W-1:0]   dl;
  logic [LEN_W-1:0]   rest;
  logic [BUILD_W-1:0] fac_x;
  logic [BUILD_W-1:0] card_x;
  logic [BUILD_W-1:0] data;
  logic [BUILD_W-1:0] lo_mask;
  logic [BUILD_W-1:0] hi_mask;
  logic [BUILD_W-1:0] w35_data;
  logic               card_over;
  logic               fac_over;

  always_comb begin
    d       = fmt_lookup(format);
    fac_x   = BUILD_W'(facility);
    card_x  = BUILD_W'(card);
    dl      = LEN_W'(d.fbits) + LEN_W'(d.cbits);
    rest    = dl - LEN_W'(d.elen);
    data    = (fac_x << d.cbits) | card_x;
    lo_mask = (BUILD_W'(1) << rest) - BUILD_W'(1);
    hi_mask = ((BUILD_W'(1) << dl) - BUILD_W'(1)) & ~lo_mask;

    card_over = (card_x >> d.cbits) != '0;
    fac_over  = (d.kind != KIND_BARE) && ((fac_x >> d.fbits) != '0);

    // W35 carries the fixed 01 prefix ahead of facility and card
    w35_data = (BUILD_W'(1) << 32) | (fac_x << 20) | card_x;

    case (d.kind)
      KIND_BARE: frame = card_x;
      KIND_W35:  frame = (BUILD_W'(^w35_data) << 34) | w35_data;
      default:   frame = (BUILD_W'(^(data & hi_mask)) << (dl + LEN_W'(1)))
                       | (data << 1)
                       | BUILD_W'(~^(data & lo_mask));
    endcase

    info.fmt_known = d.known;
    info.range_ok  = !card_over && !fac_over;
    info.len       = d.len;
  end

endmodule

>>> src/wiegand_frame_transmitter_core.sv
// Top level of the Wiegand frame transmitter: channels, timing sequencer, registers.
// Depends on wft_pkg and wft_frame_build.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transaction per step:
//   either a one-microsecond tick (cmd 0) or a start request (cmd 1) with
//   format, facility and card. Every input transaction yields exactly one
//   result transaction on out_valid/out_ready/out_data: the D0/D1 line levels,
//   busy flag, start status and the frame-done strobe.
//   Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   pulse width, gap and lead times; it is always ready and takes effect on
//   the next phase that loads a count. Write it only while the block is idle.
//   Path: two registers, input register then result register; an accepted
//   transaction moves on to the result register once that is free or being emptied.
//   Throughput: one transaction per cycle unless the receiver stalls; the whole
//   step (format lookup, parity, phase advance of up to two transitions) is one
//   combinational pass between those registers.
//   Reset (rst_n low, synchronous) restores the default times, drops any
//   frame in progress and empties both pipeline registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; in_ready drops only once both are occupied.
module wiegand_frame_transmitter_core import wft_pkg::*; #(
  parameter int FRAME_BITS  = FRAME_BITS_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int BLW  = $clog2(FRAME_BITS + 1);
  localparam int IDXW = $clog2(FRAME_BITS);
  localparam int CW   = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  // Configuration registers
  logic [CFG_W-1:0] pulse_ticks_r;
  logic [CFG_W-1:0] gap_ticks_r;
  logic [CFG_W-1:0] lead_ticks_r;

  // Pipeline registers
  logic      in_v_r;
  in_item_t  in_q_r;
  logic      out_v_r;
  out_item_t out_q_r;
  out_item_t out_nxt;

  // Frame state
  phase_t                 phase_r, phase_nxt;
  logic [FRAME_BITS-1:0]  frame_shift_r, frame_shift_nxt;
  logic [BLW-1:0]         bits_left_r, bits_left_nxt;
  logic [TIMER_WIDTH-1:0] tick_count_r, tick_count_nxt;

  logic                   advance;
  build_info_t            binfo;
  logic [BUILD_W-1:0]     bframe;
  logic [TIMER_WIDTH-1:0] lead_load, gap_load, pulse_load;
  logic [CFG_W-1:0]       pulse_min;
  logic [BLW-1:0]         bl_m1;
  logic                   cur_bit;
  status_t                status;
  logic                   done;

  // Saturate a 16-bit register value into the timer range
  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [CFG_W-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    return (ext > CW'(TMAX)) ? TMAX : ext[TIMER_WIDTH-1:0];
  endfunction

  assign pulse_min  = (pulse_ticks_r == '0) ? CFG_W'(1) : pulse_ticks_r;
  assign lead_load  = sat_load(lead_ticks_r);
  assign gap_load   = sat_load(gap_ticks_r);
  assign pulse_load = sat_load(pulse_min);

  // Advance when the result register is free or being emptied
  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_q_r;
  assign cfg_ready = 1'b1;

  wft_frame_build u_build (
    .format   (in_q_r.format),
    .facility (in_q_r.facility),
    .card     (in_q_r.card),
    .info     (binfo),
    .frame    (bframe)
  );

  // Next state: a start request or one tick of the phase sequencer
  always_comb begin
    phase_nxt       = phase_r;
    frame_shift_nxt = frame_shift_r;
    bits_left_nxt   = bits_left_r;
    tick_count_nxt  = tick_count_r;
    status          = ST_NONE;
    done            = 1'b0;

    if (in_q_r.cmd) begin
      if (phase_r != PH_IDLE) begin
        status = ST_BUSY;
      end else if (!binfo.fmt_known || int'(binfo.len) > FRAME_BITS) begin
        status = ST_BAD_FORMAT;
      end else if (!binfo.range_ok) begin
        status = ST_RANGE;
      end else begin
        status          = ST_ACCEPTED;
        frame_shift_nxt = FRAME_BITS'(bframe);
        bits_left_nxt   = BLW'(binfo.len);
        phase_nxt       = PH_LEAD;
        tick_count_nxt  = lead_load;
      end
    end else if (phase_r != PH_IDLE) begin
      // First transition of an expired phase
      if (tick_count_nxt == '0) begin
        if (phase_nxt == PH_PULSE) begin
          if (bits_left_nxt != '0) begin
            bits_left_nxt = bits_left_nxt - BLW'(1);
          end
          if (bits_left_nxt == '0) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt      = PH_GAP;
            tick_count_nxt = gap_load;
          end
        end else begin
          phase_nxt      = PH_PULSE;
          tick_count_nxt = pulse_load;
        end
      end
      // Zero gap: skip straight into the next pulse
      if (phase_nxt != PH_IDLE && tick_count_nxt == '0) begin
        phase_nxt      = PH_PULSE;
        tick_count_nxt = pulse_load;
      end
      if (phase_nxt != PH_IDLE) begin
        tick_count_nxt = tick_count_nxt - TIMER_WIDTH'(1);
      end
    end

    bl_m1   = bits_left_nxt - BLW'(1);
    cur_bit = frame_shift_nxt[bl_m1[IDXW-1:0]];

    out_nxt.d0_line    = !((phase_nxt == PH_PULSE) && !cur_bit);
    out_nxt.d1_line    = !((phase_nxt == PH_PULSE) && cur_bit);
    out_nxt.busy_res   = (phase_nxt != PH_IDLE);
    out_nxt.status     = status;
    out_nxt.frame_done = done;
  end

  // Input register: hold the transaction until it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q_r <= out_nxt;
    end
  end

  // Phase state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      frame_shift_r <= '0;
      bits_left_r   <= '0;
      tick_count_r  <= '0;
    end else if (advance) begin
      phase_r       <= phase_nxt;
      frame_shift_r <= frame_shift_nxt;
      bits_left_r   <= bits_left_nxt;
      tick_count_r  <= tick_count_nxt;
    end
  end

  // Configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= PULSE_RST;
      gap_ticks_r   <= GAP_RST;
      lead_ticks_r  <= LEAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PULSE: pulse_ticks_r <= cfg_data;
        REG_GAP:   gap_ticks_r   <= cfg_data;
        REG_LEAD:  lead_ticks_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

endmodule

>>> src/wft_checker.sv
// Port-level checks of the Wiegand frame transmitter result channel.
// Depends on wft_pkg; bound to wiegand_frame_transmitter_core below.
module wft_checker import wft_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Lines never both low
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.d0_line || out_data.d1_line))
    else $error("both data lines low");

  // Idle lines when no frame is in progress
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |-> out_data.d0_line && out_data.d1_line)
    else $error("line low while not busy");

  // Frame end reports an idle, tick-only result
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |->
      !out_data.busy_res && out_data.status == ST_NONE)
    else $error("bad frame-done result");

  // Accepted start leaves the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_ACCEPTED |-> out_data.busy_res)
    else $error("accepted start without busy");

endmodule

bind wiegand_frame_transmitter_core wft_checker u_wft_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for wiegand_frame_transmitter_core: ticks, start requests and
// timing register writes go in, every result transaction is checked against a predictor.
// Depends on wft_pkg and the core RTL only.

// Frame format codes as carried in the format field
localparam logic [3:0] FMT_W26 = 4'd0;
localparam logic [3:0] FMT_W30 = 4'd1;
localparam logic [3:0] FMT_W32 = 4'd2;
localparam logic [3:0] FMT_W34 = 4'd3;
localparam logic [3:0] FMT_W35 = 4'd4;
localparam logic [3:0] FMT_W37 = 4'd5;
localparam logic [3:0] FMT_W38 = 4'd6;
localparam logic [3:0] FMT_W40 = 4'd7;
localparam logic [3:0] FMT_W46 = 4'd8;
localparam logic [3:0] FMT_W48 = 4'd9;
localparam logic [3:0] FMT_W56 = 4'd10;
localparam logic [3:0] FMT_W64 = 4'd11;
localparam logic [3:0] FMT_UNKNOWN_LO = 4'd12;
localparam logic [3:0] FMT_UNKNOWN_HI = 4'd15;

// Register index with no register behind it
localparam logic [1:0] REG_SPARE = 2'd3;

class frame_scoreboard;
  logic [15:0]         pulse_len, gap_len, lead_len;
  logic [63:0]         frame_bits;
  logic [6:0]          bits_left;
  wft_pkg::phase_t     phase;
  logic [15:0]         ticks_left;
  wft_pkg::out_item_t  expected_q[$];
  int unsigned         error_count;
  int unsigned         result_count;

  function new();
    pulse_len   = wft_pkg::PULSE_RST;
    gap_len     = wft_pkg::GAP_RST;
    lead_len    = wft_pkg::LEAD_RST;
    frame_bits  = '0;
    bits_left   = '0;
    phase       = wft_pkg::PH_IDLE;
    ticks_left  = '0;
    error_count = 0;
    result_count = 0;
  endfunction

  function void write_reg(input logic [1:0] idx, input logic [15:0] value);
    case (idx)
      wft_pkg::REG_PULSE: pulse_len = value;
      wft_pkg::REG_GAP:   gap_len   = value;
      wft_pkg::REG_LEAD:  lead_len  = value;
      default: ;
    endcase
  endfunction

  // Advance the line sequencer by one transaction and return the result it yields
  function wft_pkg::out_item_t line_step(input wft_pkg::in_item_t it);
    wft_pkg::out_item_t r;
    wft_pkg::status_t   st;
    logic [63:0]        data, frame, low_part;
    int unsigned        flen, fac_w, card_w, even_w, data_w, odd_w;
    logic               known, stop;
    r = '{d0_line: 1'b1, d1_line: 1'b1, busy_res: 1'b0, status: wft_pkg::ST_NONE,
          frame_done: 1'b0};
    st = wft_pkg::ST_NONE;
    known = 1'b1;
    flen = 0; fac_w = 0; card_w = 0; even_w = 0;
    if (it.cmd) begin
      case (it.format)
        FMT_W26: begin flen = 26; fac_w = 8;  card_w = 16; even_w = 12; end
        FMT_W30: begin flen = 30; fac_w = 10; card_w = 20; even_w = 15; end
        FMT_W32: begin flen = 32; fac_w = 0;  card_w = 32; even_w = 0;  end
        FMT_W34: begin flen = 34; fac_w = 16; card_w = 16; even_w = 16; end
        FMT_W35: begin flen = 35; fac_w = 12; card_w = 20; even_w = 34; end
        FMT_W37: begin flen = 37; fac_w = 16; card_w = 19; even_w = 18; end
        FMT_W38: begin flen = 38; fac_w = 16; card_w = 20; even_w = 18; end
        FMT_W40: begin flen = 40; fac_w = 16; card_w = 22; even_w = 19; end
        FMT_W46: begin flen = 46; fac_w = 20; card_w = 24; even_w = 22; end
        FMT_W48: begin flen = 48; fac_w = 22; card_w = 24; even_w = 23; end
        FMT_W56: begin flen = 56; fac_w = 24; card_w = 30; even_w = 27; end
        FMT_W64: begin flen = 64; fac_w = 28; card_w = 34; even_w = 31; end
        default: known = 1'b0;
      endcase
      if (phase != wft_pkg::PH_IDLE) st = wft_pkg::ST_BUSY;
      else if (!known || flen > 64) st = wft_pkg::ST_BAD_FORMAT;
      else if ((64'(it.card) >> card_w) != 0 ||
               (it.format != FMT_W32 && (64'(it.facility) >> fac_w) != 0))
        st = wft_pkg::ST_RANGE;
      else begin
        st = wft_pkg::ST_ACCEPTED;
        if (it.format == FMT_W32) begin
          frame = 64'(it.card);
        end else if (it.format == FMT_W35) begin
          data  = (64'd1 << 32) | (64'(it.facility) << 20) | 64'(it.card);
          frame = (64'(^data) << 34) | data;
        end else begin
          data_w   = fac_w + card_w;
          odd_w    = data_w - even_w;
          data     = (64'(it.facility) << card_w) | 64'(it.card);
          low_part = data & ((64'd1 << odd_w) - 64'd1);
          frame    = (64'(^(data >> odd_w)) << (data_w + 1)) | (data << 1)
                   | 64'(~^low_part);
        end
        frame_bits = frame;
        bits_left  = 7'(flen);
        phase      = wft_pkg::PH_LEAD;
        ticks_left = lead_len;
      end
    end else if (phase != wft_pkg::PH_IDLE) begin
      stop = 1'b0;
      while (!stop && ticks_left == 0) begin
        if (phase == wft_pkg::PH_LEAD || phase == wft_pkg::PH_GAP) begin
          phase      = wft_pkg::PH_PULSE;
          ticks_left = (pulse_len == 0) ? 16'd1 : pulse_len;
        end else begin
          if (bits_left != 0) bits_left = bits_left - 7'd1;
          if (bits_left == 0) begin
            phase        = wft_pkg::PH_IDLE;
            r.frame_done = 1'b1;
            stop         = 1'b1;
          end else begin
            phase      = wft_pkg::PH_GAP;
            ticks_left = gap_len;
          end
        end
      end
      if (phase != wft_pkg::PH_IDLE) ticks_left = ticks_left - 16'd1;
    end
    if (phase == wft_pkg::PH_PULSE) begin
      if (frame_bits[(bits_left == 0) ? 7'd0 : bits_left - 7'd1]) r.d1_line = 1'b0;
      else r.d0_line = 1'b0;
    end
    r.busy_res = (phase != wft_pkg::PH_IDLE);
    r.status   = st;
    return r;
  endfunction

  function void note_input(input wft_pkg::in_item_t it);
    expected_q.push_back(line_step(it));
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  task report(input string msg);
    error_count++;
    if (error_count <= 200) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task check_field(input string name, input logic [2:0] got, input logic [2:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0d, expected %0d", result_count, name, got, want));
  endtask

  task check_result(input wft_pkg::out_item_t got);
    wft_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      report("result transaction with no input transaction waiting");
      return;
    end
    want = expected_q.pop_front();
    check_field("d0_line",    3'(got.d0_line),    3'(want.d0_line));
    check_field("d1_line",    3'(got.d1_line),    3'(want.d1_line));
    check_field("busy_res",   3'(got.busy_res),   3'(want.busy_res));
    check_field("status",     got.status,         want.status);
    check_field("frame_done", 3'(got.frame_done), 3'(want.frame_done));
    result_count++;
  endtask
endclass

module testbench;
  import wft_pkg::*;

  localparam int unsigned RUN_ITEMS  = 1000;
  localparam int unsigned MAX_PAUSE  = 17;
  // Watchdog limit, set well above the slowest expected run
  localparam int unsigned MAX_CYCLES = 3_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  frame_scoreboard sb;
  bit              calm;            // suppress idling on both channels
  int unsigned     cycle_count = 0;
  int unsigned     items_sent  = 0;

  wiegand_frame_transmitter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run as failed once the cycle limit is reached
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check each result transaction as it leaves the block
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic int unsigned pick_pause();
    return calm ? 0 : $urandom_range(0, MAX_PAUSE);
  endfunction

  // Fully random transaction: either command, any format, any field bits
  function automatic in_item_t random_item();
    in_item_t   it;
    logic [63:0] bits;
    bits        = {$urandom, $urandom};
    it.cmd      = 1'($urandom);
    it.format   = 4'($urandom);
    it.facility = 28'($urandom);
    it.card     = bits[33:0];
    return it;
  endfunction

  // Tick with random don't-care payload
  function automatic in_item_t tick_item();
    in_item_t it;
    it     = random_item();
    it.cmd = 1'b0;
    return it;
  endfunction

  function automatic in_item_t start_req(input logic [3:0] fmt, input logic [27:0] fac,
                                         input logic [33:0] card);
    in_item_t it;
    it = '{cmd: 1'b1, format: fmt, facility: fac, card: card};
    return it;
  endfunction

  // Start request whose facility and card fit the format; a quarter of them all ones
  function automatic in_item_t start_item(input logic [3:0] fmt);
    in_item_t  it;
    fmt_desc_t shape;
    it        = random_item();
    shape     = fmt_lookup(fmt);
    it.cmd    = 1'b1;
    it.format = fmt;
    if ($urandom_range(0, 3) == 0) begin
      it.facility = '1;
      it.card     = '1;
    end
    if (shape.kind != KIND_BARE) it.facility &= 28'((64'd1 << shape.fbits) - 64'd1);
    it.card &= 34'((64'd1 << shape.cbits) - 64'd1);
    return it;
  endfunction

  // Offer one transaction after a random hold-off; hold valid and payload until taken
  task automatic send_item(input in_item_t item);
    int unsigned pause;
    pause = pick_pause();
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
    items_sent++;
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write one register; keep valid high when another write follows directly
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (!hold) cfg_valid <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic program_timing(input logic [15:0] pulse, input logic [15:0] gap,
                                input logic [15:0] lead);
    wait_idle();
    cfg_write(REG_PULSE, pulse, 1'b1);
    cfg_write(REG_GAP, gap, 1'b1);
    cfg_write(REG_LEAD, lead, 1'b1);
    // The spare index must leave all timing untouched
    cfg_write(REG_SPARE, 16'($urandom), 1'b0);
  endtask

  // One frame: optional noise, a valid start, ticks until the line goes idle, then up to three more ticks
  task automatic send_frame();
    if ($urandom_range(0, 5) == 0) send_item(random_item());
    send_item(start_item(4'($urandom_range(0, 11))));
    while (sb.phase != PH_IDLE) begin
      // Sprinkle stray transactions: about half are starts, which must bounce as busy
      if ($urandom_range(0, 19) == 0) send_item(random_item());
      else send_item(tick_item());
    end
    repeat ($urandom_range(0, 3)) send_item(tick_item());
  endtask

  // Stall the result channel at random, one draw per result transaction
  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = pick_pause();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int unsigned target;
    sb = new();
    calm = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejects at reset timing, then a merged-pulse frame and busy bounces
    send_item(tick_item());                                   // tick while idle
    send_item(start_req(FMT_UNKNOWN_LO, '0, '0));
    send_item(start_req(FMT_UNKNOWN_HI, '1, '1));
    send_item(start_req(FMT_W26, 28'd256, 34'd0));            // facility too wide
    send_item(start_req(FMT_W26, 28'd0, 34'd65536));          // card too wide
    send_item(start_req(FMT_W35, 28'd4096, 34'd0));
    send_item(start_req(FMT_W32, 28'd0, 34'h1_0000_0000));
    // Zero pulse counts as one tick; zero gap and lead take no ticks
    program_timing(16'd0, 16'd0, 16'd0);
    send_item(start_req(FMT_W32, '1, 34'h0_FFFF_FFFF));       // facility is ignored
    send_item(start_req(FMT_W26, 28'd1, 34'd1));              // busy
    send_item(start_req(FMT_UNKNOWN_HI, '0, '0));             // busy beats bad format
    repeat (12) send_item(tick_item());

    // Random: the first retiming lands mid-frame, so the old frame finishes on new counts
    target = items_sent + RUN_ITEMS;
    while (items_sent < target) begin
      program_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                     16'($urandom_range(0, 4)));
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 4)) send_frame();
    end

    // Long counts: load each one once, then retime the rest of the frame short
    wait_idle();
    calm = 1'b1;
    cfg_write(REG_PULSE, 16'd40, 1'b1);
    cfg_write(REG_GAP, 16'd40, 1'b1);
    cfg_write(REG_LEAD, 16'd40, 1'b0);
    send_item(start_item(FMT_W26));
    wait_idle();
    cfg_write(REG_LEAD, 16'd0, 1'b0);
    while (sb.phase == PH_LEAD) send_item(tick_item());
    wait_idle();
    cfg_write(REG_PULSE, 16'd1, 1'b0);
    while (sb.phase == PH_PULSE) send_item(tick_item());
    wait_idle();
    cfg_write(REG_GAP, 16'd0, 1'b0);
    while (sb.phase != PH_IDLE) send_item(tick_item());
    calm = 1'b0;
    repeat (20) send_item(random_item());

    // Drain, then give the two-register path time to show any stray result
    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
